### rtl/key_ordered_task_queue_assert.svh
// assertion macros shared by the checker
`ifndef KEY_ORDERED_TASK_QUEUE_ASSERT_SVH
`define KEY_ORDERED_TASK_QUEUE_ASSERT_SVH

// same-cycle implication, held off during reset
`define KOTQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kotq check failed");

// next-cycle implication, held off during reset
`define KOTQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kotq check failed");

`endif

### rtl/kotq_pkg.sv
package kotq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_W       = 16;
  localparam int TAG_W       = 8;
  localparam int COUNT_W     = 5;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

  // one slot of the sorted chain
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } ctrl_t;

endpackage

### rtl/kotq_req_if.sv
interface kotq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [kotq_pkg::KEY_W-1:0] sort_key;
  logic [kotq_pkg::TAG_W-1:0] task_tag;

  modport source (output valid, mode, sort_key, task_tag, input ready);
  modport sink (input valid, mode, sort_key, task_tag, output ready);
endinterface

### rtl/kotq_rsp_if.sv
interface kotq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         done_res;
  logic                         head_valid;
  logic [kotq_pkg::KEY_W-1:0]   head_key;
  logic [kotq_pkg::TAG_W-1:0]   head_tag;
  logic [kotq_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, done_res, head_valid, head_key, head_tag, entry_count,
                  input ready);
  modport sink (input valid, done_res, head_valid, head_key, head_tag, entry_count,
                output ready);
endinterface

### rtl/kotq_cell.sv
module kotq_cell (
  input  logic             clk,
  input  logic             rst,
  input  kotq_pkg::ctrl_t  ctrl,
  input  kotq_pkg::entry_t left,
  input  kotq_pkg::entry_t right,
  input  logic             left_keep,
  input  logic             hit_in,
  output kotq_pkg::entry_t state,
  output logic             keep,
  output logic             hit_out
);

  kotq_pkg::entry_t slot;
  kotq_pkg::entry_t slot_next;
  logic             match;

  // entry stays put on insert when its key is not larger
  assign keep    = slot.valid && (slot.key <= ctrl.key);
  assign match   = slot.valid && (slot.tag == ctrl.tag);
  assign hit_out = hit_in | match;
  assign state   = slot;

  always_comb begin
    slot_next = slot;
    if (ctrl.ins && !keep) begin
      if (left_keep) begin
        slot_next.valid = 1'b1;
        slot_next.key   = ctrl.key;
        slot_next.tag   = ctrl.tag;
      end else begin
        slot_next = left;
      end
    end else if (ctrl.rem && hit_out) begin
      slot_next = right;
    end
  end

  // only the valid bit is reset, key and tag follow along
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
    slot.key <= slot_next.key;
    slot.tag <= slot_next.tag;
  end

endmodule

### rtl/key_ordered_task_queue.sv
// key ordered task queue: sorted list of up to QUEUE_DEPTH task entries
//
// req channel carries one operation per transaction: mode insert places
// sort_key/task_tag behind every held entry with an equal or smaller key,
// mode remove deletes the first entry in key order whose tag matches
// rsp channel returns one transaction per request: done_res, the head entry
// (zero when empty) and the entry count after the operation
//
// storage is a chain of cells, slot 0 the head; every cell compares its own
// key and tag with the broadcast operation and either holds, loads the new
// entry, or copies its left or right neighbor, so the whole list shifts
// together on the same clock edge
// the result is valid in the cycle after the request is accepted
// throughput: one operation per cycle while rsp is taken every cycle
// a full queue rejects an insert with done_res low; a missing tag leaves
// the queue untouched
// reset empties the queue at once (valid bits only, no clearing pass)
// when rsp stalls, the result register holds and req.ready drops until the
// pending transaction is taken
module key_ordered_task_queue (
  input logic        clk,
  input logic        rst,
  kotq_req_if.sink   req,
  kotq_rsp_if.source rsp
);

  kotq_pkg::entry_t cell_state [kotq_pkg::QUEUE_DEPTH];
  logic             cell_keep  [kotq_pkg::QUEUE_DEPTH];
  logic             cell_hit   [kotq_pkg::QUEUE_DEPTH];
  kotq_pkg::ctrl_t  ctrl;

  logic                       accept;
  logic                       full;
  logic                       ins_ok;
  logic                       rem_ok;
  logic                       out_valid;
  logic                       done_q;
  logic [kotq_pkg::CNT_W-1:0] held_count;
  logic [kotq_pkg::CNT_W-1:0] held_count_next;

  // result register frees the input side as soon as it is taken
  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // valid slots are contiguous from the head, so the tail slot tells full
  assign full   = cell_state[kotq_pkg::QUEUE_DEPTH-1].valid;
  assign ins_ok = accept && (req.mode == kotq_pkg::MODE_INSERT) && !full;
  assign rem_ok = accept && (req.mode == kotq_pkg::MODE_REMOVE)
                  && cell_hit[kotq_pkg::QUEUE_DEPTH-1];

  // broadcast operation; a rejected insert reaches no cell
  assign ctrl.ins = ins_ok;
  assign ctrl.rem = accept && (req.mode == kotq_pkg::MODE_REMOVE);
  assign ctrl.key = req.sort_key;
  assign ctrl.tag = req.task_tag;

  for (genvar i = 0; i < kotq_pkg::QUEUE_DEPTH; i++) begin : g_cell
    kotq_pkg::entry_t left;
    kotq_pkg::entry_t right;
    logic             left_keep;
    logic             hit_in;

    if (i == 0) begin : g_head
      // head cell always loads the new entry once its own entry moves on
      assign left      = '0;
      assign left_keep = 1'b1;
      assign hit_in    = 1'b0;
    end else begin : g_body
      assign left      = cell_state[i-1];
      assign left_keep = cell_keep[i-1];
      assign hit_in    = cell_hit[i-1];
    end

    if (i == kotq_pkg::QUEUE_DEPTH - 1) begin : g_tail
      // tail drops to empty when the list closes a gap
      assign right = '0;
    end else begin : g_inner
      assign right = cell_state[i+1];
    end

    kotq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .left      (left),
      .right     (right),
      .left_keep (left_keep),
      .hit_in    (hit_in),
      .state     (cell_state[i]),
      .keep      (cell_keep[i]),
      .hit_out   (cell_hit[i])
    );
  end

  always_comb begin
    held_count_next = held_count;
    if (ins_ok) begin
      held_count_next = held_count + 1'b1;
    end else if (rem_ok) begin
      held_count_next = held_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      held_count <= held_count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      done_q <= ins_ok || rem_ok;
    end
  end

  // head and count come straight from state, which only moves on accept
  assign rsp.valid       = out_valid;
  assign rsp.done_res    = done_q;
  assign rsp.head_valid  = cell_state[0].valid;
  assign rsp.head_key    = cell_state[0].valid ? cell_state[0].key : '0;
  assign rsp.head_tag    = cell_state[0].valid ? cell_state[0].tag : '0;
  assign rsp.entry_count = kotq_pkg::COUNT_W'(held_count);

endmodule

### rtl/kotq_checker.sv
`include "key_ordered_task_queue_assert.svh"

module kotq_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         done_res,
  input logic                         head_valid,
  input logic [kotq_pkg::KEY_W-1:0]   head_key,
  input logic [kotq_pkg::TAG_W-1:0]   head_tag,
  input logic [kotq_pkg::COUNT_W-1:0] entry_count
);

  // every accepted request produces a result in the next cycle
  `KOTQ_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid)

  // head flag agrees with the reported count
  `KOTQ_ASSERT_NOW(a_head_matches_count, out_valid,
                   head_valid == (entry_count != '0))

  // an empty queue reports a zero head
  `KOTQ_ASSERT_NOW(a_empty_head_zero, out_valid && !head_valid,
                   (head_key == '0) && (head_tag == '0))

  // a stalled result holds its payload
  `KOTQ_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
                    out_valid && $stable(done_res) && $stable(head_key)
                    && $stable(head_tag) && $stable(entry_count))

endmodule

bind key_ordered_task_queue kotq_checker u_kotq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .done_res    (rsp.done_res),
  .head_valid  (rsp.head_valid),
  .head_key    (rsp.head_key),
  .head_tag    (rsp.head_tag),
  .entry_count (rsp.entry_count)
);
